@@ hw/rtl/i2cm_pkg.sv @@
// Shared types and codes for the I2C bus monitor decoder.
package i2cm_pkg;

    // Decode phase codes.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_RESTART = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_ACK     = 3'd4;

    // Symbol kind codes.
    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_RESTART = 3'd1;
    localparam logic [2:0] KIND_STOP    = 3'd2;
    localparam logic [2:0] KIND_ADDR    = 3'd3;
    localparam logic [2:0] KIND_DATA    = 3'd4;
    localparam logic [2:0] KIND_ACK     = 3'd5;
    localparam logic [2:0] KIND_PKTEND  = 3'd6;

    // Bits in one byte on the bus, and the saturation point of the byte counter.
    localparam logic [3:0]  BYTE_BITS      = 4'd8;
    localparam logic [15:0] PKT_BYTES_MAX  = 16'hFFFF;

    // Decoder state that does not depend on the time width.
    typedef struct packed {
        logic        prev_sda;
        logic        prev_scl;
        logic [2:0]  phase;
        logic [7:0]  shift_byte;
        logic [3:0]  bits_seen;
        logic        after_start;
        logic        pkt_open;
        logic [15:0] pkt_bytes;
    } dec_state_t;

    // Non-time fields of one decoded word.
    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  value;
        logic        closed;
        logic [15:0] byte_count;
    } dec_result_t;

endpackage

@@ hw/rtl/i2c_bus_monitor_decoder.sv @@
// Passive I2C bus monitor: decodes timestamped SDA/SCL samples into bus symbols.
//
// Each accepted sample word is held in an input register and decoded from there into at
// most one symbol word (start, restart, stop, address, data, ACK/NAK or packet end),
// which is held in an output register until taken. The block takes one sample per clock
// cycle; the single decode stage between the two registers sets that rate, and a sample
// waits only while its symbol finds the output register still full. Times are kept to
// TIME_BITS bits and durations wrap modulo 2^TIME_BITS.
module i2c_bus_monitor_decoder #(
    parameter int TIME_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        sda_level,
    input  logic        scl_level,
    input  logic [47:0] sample_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  symbol_kind,
    output logic [7:0]  symbol_value,
    output logic [47:0] symbol_begin,
    output logic [47:0] symbol_length,
    output logic        packet_closed,
    output logic [15:0] packet_byte_count,
    output logic [47:0] packet_begin,
    output logic [47:0] packet_length
);

    // Decoder state after reset: both lines high, idle, no packet open.
    localparam i2cm_pkg::dec_state_t STATE_RESET = '{
        prev_sda:    1'b1,
        prev_scl:    1'b1,
        phase:       i2cm_pkg::PH_IDLE,
        shift_byte:  8'd0,
        bits_seen:   4'd0,
        after_start: 1'b0,
        pkt_open:    1'b0,
        pkt_bytes:   16'd0
    };

    // Input register.
    logic                  in_valid_reg;
    logic                  in_sda_reg;
    logic                  in_scl_reg;
    logic [TIME_BITS-1:0]  in_time_reg;

    // Decoder state.
    i2cm_pkg::dec_state_t  state_reg;
    i2cm_pkg::dec_state_t  state_next;
    logic [TIME_BITS-1:0]  sym_begin_reg;
    logic [TIME_BITS-1:0]  sym_begin_next;
    logic [TIME_BITS-1:0]  pkt_begin_reg;
    logic [TIME_BITS-1:0]  pkt_begin_next;

    // Decode results.
    i2cm_pkg::dec_result_t result;
    logic [TIME_BITS-1:0]  res_sym_begin;
    logic [TIME_BITS-1:0]  res_sym_length;
    logic [TIME_BITS-1:0]  res_pkt_begin;
    logic [TIME_BITS-1:0]  res_pkt_length;

    // Output register.
    logic                  out_valid_reg;
    logic [2:0]            kind_reg;
    logic [7:0]            value_reg;
    logic [47:0]           sym_begin_out_reg;
    logic [47:0]           sym_length_out_reg;
    logic                  closed_reg;
    logic [15:0]           byte_count_reg;
    logic [47:0]           pkt_begin_out_reg;
    logic [47:0]           pkt_length_out_reg;

    logic                  advance;

    i2cm_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .state          (state_reg),
        .sym_begin      (sym_begin_reg),
        .pkt_begin      (pkt_begin_reg),
        .sda            (in_sda_reg),
        .scl            (in_scl_reg),
        .now            (in_time_reg),
        .state_next     (state_next),
        .sym_begin_next (sym_begin_next),
        .pkt_begin_next (pkt_begin_next),
        .result         (result),
        .res_sym_begin  (res_sym_begin),
        .res_sym_length (res_sym_length),
        .res_pkt_begin  (res_pkt_begin),
        .res_pkt_length (res_pkt_length)
    );

    // The held sample is decoded once its word, if any, has room in the output register.
    assign advance  = in_valid_reg && (!result.valid || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_sda_reg  <= sda_level;
            in_scl_reg  <= scl_level;
            in_time_reg <= TIME_BITS'(sample_time);
        end
    end

    // Decoder state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            sym_begin_reg <= '0;
            pkt_begin_reg <= '0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            sym_begin_reg <= sym_begin_next;
            pkt_begin_reg <= pkt_begin_next;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            kind_reg           <= result.kind;
            value_reg          <= result.value;
            sym_begin_out_reg  <= 48'(res_sym_begin);
            sym_length_out_reg <= 48'(res_sym_length);
            closed_reg         <= result.closed;
            byte_count_reg     <= result.byte_count;
            pkt_begin_out_reg  <= 48'(res_pkt_begin);
            pkt_length_out_reg <= 48'(res_pkt_length);
        end
    end

    assign out_valid         = out_valid_reg;
    assign symbol_kind       = kind_reg;
    assign symbol_value      = value_reg;
    assign symbol_begin      = sym_begin_out_reg;
    assign symbol_length     = sym_length_out_reg;
    assign packet_closed     = closed_reg;
    assign packet_byte_count = byte_count_reg;
    assign packet_begin      = pkt_begin_out_reg;
    assign packet_length     = pkt_length_out_reg;

    // Only a stop or a packet end closes a packet.
    a_close_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && closed_reg |->
            (kind_reg == i2cm_pkg::KIND_STOP) || (kind_reg == i2cm_pkg::KIND_PKTEND))
        else $error("packet closed by a symbol that is neither stop nor packet end");

    // A packet end word always has zero symbol length.
    a_pktend_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == i2cm_pkg::KIND_PKTEND) |->
            (sym_length_out_reg == 48'd0) && closed_reg)
        else $error("packet end word with non-zero length or not closing");

    // The bit counter never passes a full byte.
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bits_seen <= i2cm_pkg::BYTE_BITS)
        else $error("bit counter beyond one byte");

    // A stop always leaves the decoder idle with no packet open.
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.valid && (result.kind == i2cm_pkg::KIND_STOP) |=>
            (state_reg.phase == i2cm_pkg::PH_IDLE) && !state_reg.pkt_open)
        else $error("decoder not idle after stop");

endmodule

@@ hw/rtl/i2cm_step.sv @@
// Combinational decode of one SDA/SCL sample against the current decoder state.
module i2cm_step #(
    parameter int TIME_BITS = 48
) (
    input  i2cm_pkg::dec_state_t  state,
    input  logic [TIME_BITS-1:0]  sym_begin,
    input  logic [TIME_BITS-1:0]  pkt_begin,
    input  logic                  sda,
    input  logic                  scl,
    input  logic [TIME_BITS-1:0]  now,
    output i2cm_pkg::dec_state_t  state_next,
    output logic [TIME_BITS-1:0]  sym_begin_next,
    output logic [TIME_BITS-1:0]  pkt_begin_next,
    output i2cm_pkg::dec_result_t result,
    output logic [TIME_BITS-1:0]  res_sym_begin,
    output logic [TIME_BITS-1:0]  res_sym_length,
    output logic [TIME_BITS-1:0]  res_pkt_begin,
    output logic [TIME_BITS-1:0]  res_pkt_length
);

    logic                 start_cond;
    logic                 stop_cond;
    logic                 scl_rise;
    logic                 in_start_sym;
    logic [3:0]           bits_inc;
    logic [7:0]           shift_inc;
    logic [TIME_BITS-1:0] sym_len_now;
    logic [TIME_BITS-1:0] pkt_len_now;

    // Line events and the running durations.
    assign start_cond   = !sda && state.prev_sda && scl;
    assign stop_cond    = sda && !state.prev_sda && scl;
    assign scl_rise     = scl && !state.prev_scl;
    assign in_start_sym = (state.phase == i2cm_pkg::PH_START)
                       || (state.phase == i2cm_pkg::PH_RESTART);
    assign bits_inc     = state.bits_seen + 4'd1;
    assign shift_inc    = {state.shift_byte[6:0], sda};
    assign sym_len_now  = now - sym_begin;
    assign pkt_len_now  = now - pkt_begin;

    // Event decode in priority order: start, end of start symbol, stop, clock edge.
    always_comb
    begin
        state_next          = state;
        state_next.prev_sda = sda;
        state_next.prev_scl = scl;
        sym_begin_next      = sym_begin;
        pkt_begin_next      = pkt_begin;
        result              = '0;
        res_sym_begin       = sym_begin;
        res_sym_length      = sym_len_now;
        res_pkt_begin       = '0;
        res_pkt_length      = '0;

        priority if (start_cond)
        begin
            if (state.phase == i2cm_pkg::PH_DATA)
            begin
                // Restart in the data phase: the open packet ends here.
                state_next.phase = i2cm_pkg::PH_RESTART;
                if (state.pkt_open)
                begin
                    result.valid      = 1'b1;
                    result.kind       = i2cm_pkg::KIND_PKTEND;
                    result.closed     = 1'b1;
                    result.byte_count = state.pkt_bytes;
                    res_sym_begin     = now;
                    res_sym_length    = '0;
                    res_pkt_begin     = pkt_begin;
                    res_pkt_length    = pkt_len_now;
                end
            end
            else
            begin
                sym_begin_next   = now;
                state_next.phase = i2cm_pkg::PH_START;
            end
            state_next.pkt_open  = 1'b1;
            state_next.pkt_bytes = '0;
            pkt_begin_next       = now;
        end
        else if (in_start_sym && (sda || !scl))
        begin
            result.valid           = 1'b1;
            result.kind            = (state.phase == i2cm_pkg::PH_START)
                                   ? i2cm_pkg::KIND_START : i2cm_pkg::KIND_RESTART;
            state_next.after_start = 1'b1;
            state_next.phase       = i2cm_pkg::PH_DATA;
            sym_begin_next         = now;
            state_next.bits_seen   = '0;
            state_next.shift_byte  = '0;
        end
        else if (stop_cond)
        begin
            result.valid = 1'b1;
            result.kind  = i2cm_pkg::KIND_STOP;
            if (state.pkt_open)
            begin
                result.closed       = 1'b1;
                result.byte_count   = state.pkt_bytes;
                res_pkt_begin       = pkt_begin;
                res_pkt_length      = pkt_len_now;
                state_next.pkt_open = 1'b0;
            end
            state_next.after_start = 1'b0;
            sym_begin_next         = now;
            state_next.phase       = i2cm_pkg::PH_IDLE;
        end
        else if (scl_rise)
        begin
            if (state.phase == i2cm_pkg::PH_DATA)
            begin
                state_next.bits_seen  = bits_inc;
                state_next.shift_byte = shift_inc;
                if (bits_inc >= i2cm_pkg::BYTE_BITS)
                begin
                    // A full byte has been clocked in.
                    result.valid = 1'b1;
                    result.value = shift_inc;
                    if (state.after_start)
                    begin
                        result.kind = i2cm_pkg::KIND_ADDR;
                    end
                    else
                    begin
                        result.kind = i2cm_pkg::KIND_DATA;
                        if (state.pkt_open && (state.pkt_bytes != i2cm_pkg::PKT_BYTES_MAX))
                        begin
                            state_next.pkt_bytes = state.pkt_bytes + 16'd1;
                        end
                    end
                    state_next.after_start = 1'b0;
                    state_next.bits_seen   = '0;
                    state_next.shift_byte  = '0;
                    sym_begin_next         = now;
                    state_next.phase       = i2cm_pkg::PH_ACK;
                end
            end
            else if (state.phase == i2cm_pkg::PH_ACK)
            begin
                result.valid           = 1'b1;
                result.kind            = i2cm_pkg::KIND_ACK;
                result.value           = {7'd0, sda};
                state_next.after_start = 1'b0;
                sym_begin_next         = now;
                state_next.phase       = i2cm_pkg::PH_DATA;
            end
        end
    end

endmodule
